// ===== rtl/run_weighted_decision_smoother_unit_assert.svh =====
`ifndef RUN_WEIGHTED_DECISION_SMOOTHER_UNIT_ASSERT_SVH
`define RUN_WEIGHTED_DECISION_SMOOTHER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RWDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RWDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rwds_pkg.sv =====
package rwds_pkg;

  // Width and reset value of the history length register.
  localparam int HIST_LEN_W     = 6;
  localparam int HIST_LEN_RESET = 30;

  // Default number of history entries held in the block.
  localparam int MAX_HISTORY_DEF = 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic passthrough;
    logic scan_last;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/rwds_ctrl.sv =====
module rwds_ctrl
  import rwds_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.passthrough ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.scan_last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    in_ready      = 1'b0;
    cmd.capture   = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.finish    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_DONE: begin
        cmd.finish = !status.out_busy;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/rwds_dp.sv =====
module rwds_dp
  import rwds_pkg::*;
#(
  parameter int MaxHistory = MAX_HISTORY_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [HIST_LEN_W-1:0] cfg_wdata,
  input  logic                  raw_decision,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  smoothed_decision,
  input  cmd_t                  cmd,
  output status_t               status
);

  localparam int CntW    = $clog2(MaxHistory + 1);
  localparam int CmpW    = (CntW > HIST_LEN_W) ? CntW : HIST_LEN_W;
  localparam int WeightW = $clog2(MaxHistory * (MaxHistory + 1) / 2 + 2);

  logic [HIST_LEN_W-1:0] hist_len;
  logic [MaxHistory-1:0] hist;
  logic [MaxHistory-1:0] hist_rot;
  logic [MaxHistory-1:0] hist_ins;
  logic [CntW-1:0]       fill;
  logic [CntW-1:0]       n_eff;
  logic                  cur;
  logic                  pass;
  logic [CntW-1:0]       idx;
  logic [CntW-1:0]       run;
  logic [CntW-1:0]       run_next;
  logic                  prev;
  logic                  scan_bit;
  logic                  in_range;
  logic [WeightW-1:0]    true_w;
  logic [WeightW-1:0]    false_w;
  logic                  vote;

  // Effective history length, saturated at the number of stored entries.
  always_comb begin
    if (CmpW'(hist_len) > CmpW'(MaxHistory)) begin
      n_eff = CntW'(MaxHistory);
    end else begin
      n_eff = CntW'(hist_len);
    end
  end

  // The scan rotates the whole vector once, so the oldest entry comes to bit 0 first.
  always_comb begin
    for (int k = 0; k < MaxHistory; k++) begin
      hist_rot[k] = hist[(k + 1) % MaxHistory];
    end
  end

  // Shift the active entries toward the oldest end and insert the new decision.
  always_comb begin
    for (int k = 0; k < MaxHistory; k++) begin
      if (CntW'(k + 1) < n_eff) begin
        hist_ins[k] = hist[k + 1];
      end else if (CntW'(k + 1) == n_eff) begin
        hist_ins[k] = cur;
      end else begin
        hist_ins[k] = hist[k];
      end
    end
  end

  // Run length of equal values ending at the entry under the scan.
  assign scan_bit = hist[0];
  assign in_range = idx < n_eff;
  always_comb begin
    if ((idx == '0) || (scan_bit != prev)) begin
      run_next = CntW'(1);
    end else begin
      run_next = run + CntW'(1);
    end
  end

  // The new decision adds a weight of one to its side.
  assign vote = ({1'b0, true_w} + (WeightW + 1)'(cur)) >
                ({1'b0, false_w} + (WeightW + 1)'(!cur));

  // Configuration, history and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_len <= HIST_LEN_W'(HIST_LEN_RESET);
      hist     <= '0;
      fill     <= '0;
    end else if (cfg_we) begin
      hist_len <= cfg_wdata;
      hist     <= '0;
      fill     <= '0;
    end else if (cmd.scan_step) begin
      hist <= hist_rot;
    end else if (cmd.finish && (n_eff != '0)) begin
      hist <= hist_ins;
      if (fill < n_eff) begin
        fill <= fill + CntW'(1);
      end
    end
  end

  // Request capture and weight accumulation.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur     <= raw_decision;
      pass    <= status.passthrough;
      idx     <= '0;
      run     <= '0;
      prev    <= 1'b0;
      true_w  <= '0;
      false_w <= '0;
    end else if (cmd.scan_step) begin
      idx <= idx + CntW'(1);
      if (in_range) begin
        run  <= run_next;
        prev <= scan_bit;
        if (scan_bit) begin
          true_w <= true_w + WeightW'(run_next);
        end else begin
          false_w <= false_w + WeightW'(run_next);
        end
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      smoothed_decision <= pass ? cur : vote;
    end
  end

  // Status toward the controller.
  assign status.passthrough = (n_eff == '0) || (fill < n_eff);
  assign status.scan_last   = idx == CntW'(MaxHistory - 1);
  assign status.out_busy    = out_valid && !out_ready;

endmodule

// ===== rtl/run_weighted_decision_smoother_unit.sv =====
// A request is captured in IDLE and goes straight to DONE while the history fills or the
// length is zero; once the history is full, the SCAN state runs before DONE. No new request
// is taken until the result has been registered and the block is back in IDLE; the
// serial scan rotates the whole history past one bit per cycle.
// Reset (synchronous, active high) sets the length to 30 and clears history and fill count.
module run_weighted_decision_smoother_unit
  import rwds_pkg::*;
#(
  parameter int MaxHistory = MAX_HISTORY_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [HIST_LEN_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  raw_decision,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  smoothed_decision
);

  cmd_t    cmd;
  status_t status;

  // Sequencer.
  rwds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // History, vote and output register.
  rwds_dp #(
    .MaxHistory (MaxHistory)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .raw_decision      (raw_decision),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .smoothed_decision (smoothed_decision),
    .cmd               (cmd),
    .status            (status)
  );

endmodule

// ===== rtl/rwds_checker.sv =====
`include "run_weighted_decision_smoother_unit_assert.svh"

module rwds_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic smoothed_decision
);

  // A stalled result stays offered.
  `RWDS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")

  // A stalled result keeps its value.
  `RWDS_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(smoothed_decision), "result changed while stalled")

  // One request at a time: after an accept the input side closes.
  `RWDS_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready, "second request taken while busy")

  // No result is offered right after reset.
  `RWDS_ASSERT_NOW(a_reset_empty, clk, rst, $fell(rst), !out_valid, "result offered after reset")

endmodule

bind run_weighted_decision_smoother_unit rwds_checker u_rwds_checker (.*);

// ===== bench/run_weighted_decision_smoother_unit_tb.sv =====
`default_nettype none

module run_weighted_decision_smoother_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rwds_pkg::*;

  localparam int StallLimit = 1000;
  localparam int DrainCycles = MAX_HISTORY_DEF + 4;

  // Tracks the smoother's history and the votes it owes, one per accepted request.
  class vote_scoreboard;
    logic [HIST_LEN_W-1:0] length_reg;
    logic history [MAX_HISTORY_DEF];
    int unsigned fill;
    logic expected_votes[$];
    int unsigned errors;

    function new();
      errors = 0;
      set_length(HIST_LEN_W'(HIST_LEN_RESET));
    endfunction

    // Any write of the length clears the history and the fill count.
    function void set_length(input logic [HIST_LEN_W-1:0] len);
      length_reg = len;
      foreach (history[i]) history[i] = 1'b0;
      fill = 0;
    endfunction

    function int unsigned pending();
      return expected_votes.size();
    endfunction

    // Works out the vote for one accepted request and shifts it into the history.
    function void note_decision(input logic raw);
      int unsigned n;
      int unsigned weight_true;
      int unsigned weight_false;
      int unsigned run_len;
      logic vote;
      n = (length_reg > MAX_HISTORY_DEF) ? MAX_HISTORY_DEF : length_reg;
      if (n == 0) begin
        expected_votes.push_back(raw);
        return;
      end
      if (fill < n) begin
        vote = raw;
      end else begin
        weight_true = 0;
        weight_false = 0;
        run_len = 1;
        for (int i = 0; i < n; i++) begin
          if (i > 0) run_len = (history[i] == history[i-1]) ? run_len + 1 : 1;
          if (history[i]) weight_true += run_len;
          else weight_false += run_len;
        end
        if (raw) weight_true++;
        else weight_false++;
        vote = (weight_true > weight_false);
      end
      for (int i = 0; i + 1 < n; i++) history[i] = history[i+1];
      history[n-1] = raw;
      if (fill < n) fill++;
      expected_votes.push_back(vote);
    endfunction

    // Compares one delivered result with the oldest vote still owed.
    function void check_vote(input logic actual);
      logic want;
      if (expected_votes.size() == 0) begin
        if (errors < 10) $display("smoothed_decision %0b delivered with no request pending",
                                  actual);
        errors++;
        return;
      end
      want = expected_votes.pop_front();
      if (actual !== want) begin
        if (errors < 10) $display("smoothed_decision mismatch: expected %0b, got %0b",
                                  want, actual);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [HIST_LEN_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic raw_decision = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic smoothed_decision;

  int unsigned send_idle_pct = 23;
  int unsigned recv_idle_pct = 60;
  int unsigned stalled_cycles = 0;
  vote_scoreboard sb = new();

  run_weighted_decision_smoother_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .raw_decision(raw_decision),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .smoothed_decision(smoothed_decision)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver stalls at random.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Handshake monitor and watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_decision(raw_decision);
      if (out_valid && out_ready) sb.check_vote(smoothed_decision);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
        if (stalled_cycles >= StallLimit) begin
          $display("Verification failed");
          $finish;
        end
      end
    end
  end

  // Offers one request, with a random gap first, and returns once it is taken.
  task automatic send_decision(input logic raw);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    raw_decision <= raw;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_bits(input logic [15:0] bits, input int count);
    for (int i = 0; i < count; i++) send_decision(bits[i]);
  endtask

  // Lets the block go idle, then writes the history length.
  task automatic write_length(input logic [HIST_LEN_W-1:0] len);
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_length(len);
  endtask

  // Mostly runs of equal decisions with a random flip rate, some plain noise.
  task automatic run_phase(input logic [HIST_LEN_W-1:0] len);
    logic bit_now;
    int unsigned flip_pct;
    int unsigned eff;
    int unsigned count;
    eff = (len > MAX_HISTORY_DEF) ? MAX_HISTORY_DEF : len;
    count = eff + 18;
    flip_pct = $urandom_range(5, 60);
    bit_now = 1'($urandom_range(0, 1));
    write_length(len);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 99) < flip_pct) bit_now = ~bit_now;
      end else begin
        bit_now = 1'($urandom_range(0, 1));
      end
      send_decision(bit_now);
    end
  endtask

  initial begin
    int phase_lengths [12];
    phase_lengths = '{32, 63, 7, 1, 0, 33, 2, 16, 3, 31, 0, 0};
    phase_lengths[10] = $urandom_range(0, 63);
    phase_lengths[11] = $urandom_range(0, 63);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset length of 30: the history is filling, so decisions pass through.
    send_bits(16'b101, 3);
    // Length zero passes decisions through.
    write_length(6'd0);
    send_bits(16'b10, 2);
    // Length one: one fill request, then a vote of the stored entry against the new one.
    write_length(6'd1);
    send_bits(16'b01011, 5);
    // Length two: runs of equal entries weigh more.
    write_length(6'd2);
    send_bits(16'b110011, 6);
    // Rewriting an unchanged length still clears the history.
    write_length(6'd2);
    send_bits(16'b11, 2);
    // Lengths above the history depth saturate.
    write_length(6'd63);
    send_bits(16'b10, 2);

    // Random phases: the receiver idles more first, then the sender, then neither.
    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        send_idle_pct = 23;
        recv_idle_pct = 60;
      end else if (p < 8) begin
        send_idle_pct = 60;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      run_phase(HIST_LEN_W'(phase_lengths[p]));
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
